>>> design/dvpd_pkg.sv
// Shared widths and code constants for the delta varint position decoder.
`timescale 1ns / 1ps

package dvpd_pkg;

   localparam int BYTE_W    = 8;
   localparam int POS_W     = 32;
   localparam int LIST_W    = 16;
   localparam int REM_W     = 3;
   localparam int MAX_LISTS = 65536;

   localparam logic [LIST_W-1:0] LAST_LIST  = LIST_W'(MAX_LISTS - 1);
   localparam logic [LIST_W-1:0] LIST_RESET = '1;

   // Leading byte classes
   localparam logic [BYTE_W-1:0] LEAD_LONG  = 8'd0;
   localparam logic [BYTE_W-1:0] LEAD_TWO   = 8'd192;
   localparam logic [BYTE_W-1:0] LEAD_ONE   = 8'd128;
   localparam logic [BYTE_W-1:0] SHORT_BIAS = 8'd64;

   localparam logic [REM_W-1:0] REM_LONG = 3'd4;
   localparam logic [REM_W-1:0] REM_TWO  = 3'd2;
   localparam logic [REM_W-1:0] REM_ONE  = 3'd1;
   localparam logic [REM_W-1:0] REM_NONE = 3'd0;

endpackage

>>> design/delta_varint_position_decoder_unit.sv
// Delta varint position decoder: byte parser, delta accumulator, result register.
`timescale 1ns / 1ps

// A result appears in the cycle after the byte that completes its code.
// One byte per cycle unless req_stall; position, partial, rem, list each feed back.
// req_stall rises only while a finished item sits unaccepted in the result register.
// Reset (synchronous): position 0, no code in progress, list index all ones,
// result register empty.
module delta_varint_position_decoder_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [dvpd_pkg::BYTE_W-1:0]  req_code_byte,
   input  logic                         req_list_start,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [dvpd_pkg::POS_W-1:0]   rsp_position,
   output logic [dvpd_pkg::LIST_W-1:0]  rsp_list_index
);

   logic [dvpd_pkg::POS_W-1:0]  prev_ff, prev_in;
   logic [dvpd_pkg::POS_W-1:0]  partial_ff, partial_in;
   logic [dvpd_pkg::REM_W-1:0]  rem_ff, rem_in;
   logic [dvpd_pkg::LIST_W-1:0] list_ff, list_in;
   logic                        valid_ff, valid_in;
   logic [dvpd_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [dvpd_pkg::LIST_W-1:0] idx_ff;

   logic                        req_acc;
   logic                        emit;
   logic [dvpd_pkg::POS_W-1:0]  delta;
   logic [dvpd_pkg::POS_W-1:0]  base;

   assign req_stall = valid_ff && rsp_stall;
   assign req_acc   = req_valid && !req_stall;

   always_comb begin
      prev_in    = prev_ff;
      partial_in = partial_ff;
      rem_in     = rem_ff;
      list_in    = list_ff;
      emit       = 1'b0;
      delta      = '0;
      base       = prev_ff;
      if (rem_ff != dvpd_pkg::REM_NONE) begin
         partial_in = {partial_ff[dvpd_pkg::POS_W-dvpd_pkg::BYTE_W-1:0], req_code_byte};
         rem_in     = rem_ff - dvpd_pkg::REM_ONE;
         emit       = (rem_ff == dvpd_pkg::REM_ONE);
         delta      = partial_in;
      end else begin
         if (req_list_start) begin
            // advance list and restart the position at zero
            list_in = (list_ff == dvpd_pkg::LAST_LIST) ? '0 : list_ff + 1'b1;
            prev_in = '0;
            base    = '0;
         end
         if (req_code_byte == dvpd_pkg::LEAD_LONG) begin
            partial_in = '0;
            rem_in     = dvpd_pkg::REM_LONG;
         end else if (req_code_byte >= dvpd_pkg::LEAD_TWO) begin
            partial_in = dvpd_pkg::POS_W'(req_code_byte[5:0]);
            rem_in     = dvpd_pkg::REM_TWO;
         end else if (req_code_byte >= dvpd_pkg::LEAD_ONE) begin
            partial_in = dvpd_pkg::POS_W'(req_code_byte[5:0]);
            rem_in     = dvpd_pkg::REM_ONE;
         end else begin
            // wrap the bias subtraction at the byte width
            emit  = 1'b1;
            delta = dvpd_pkg::POS_W'(dvpd_pkg::BYTE_W'(req_code_byte - dvpd_pkg::SHORT_BIAS));
         end
      end
      pos_in = base + delta;
      if (emit) begin
         prev_in = pos_in;
      end
      valid_in = req_acc ? emit : (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff    <= '0;
         partial_ff <= '0;
         rem_ff     <= dvpd_pkg::REM_NONE;
         list_ff    <= dvpd_pkg::LIST_RESET;
         valid_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (req_acc) begin
            prev_ff    <= prev_in;
            partial_ff <= partial_in;
            rem_ff     <= rem_in;
            list_ff    <= list_in;
         end
      end
   end

   // Payload: load only when a new item completes
   always_ff @(posedge clock) begin
      if (req_acc && emit) begin
         pos_ff <= pos_in;
         idx_ff <= list_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_position   = pos_ff;
   assign rsp_list_index = idx_ff;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> valid_ff)
      else $error("input stalled with empty result register");

   a_result_tracks_prev: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (prev_ff == pos_ff))
      else $error("held position differs from running position");

   a_last_byte_emits: assert property (@(posedge clock) disable iff (reset)
      (req_acc && rem_ff == dvpd_pkg::REM_ONE) |=>
         (valid_ff && pos_ff == $past(prev_ff +
            {partial_ff[dvpd_pkg::POS_W-dvpd_pkg::BYTE_W-1:0], req_code_byte})))
      else $error("final byte of a code did not give prev plus delta");

   a_list_advance: assert property (@(posedge clock) disable iff (reset)
      (req_acc && rem_ff == dvpd_pkg::REM_NONE && req_list_start) |=>
         (list_ff == $past(list_ff) + 1'b1 && prev_ff == pos_ff || !valid_ff && prev_ff == '0
          && list_ff == $past(list_ff) + 1'b1))
      else $error("list start did not advance the list index");

endmodule
